### design/spq_pkg.sv
// Shared codes and control types for the sorted priority queue.
// No dependencies.
package spq_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic       latch;     // capture request fields
      logic       do_insert;
      logic       do_pop;
      logic       load_hit;  // mark cells whose id matches
      logic       spread;    // one step of the prefix-OR over the hit marks
      logic       do_remove;
      logic       finish;    // load the response registers
      logic [1:0] status;
   } spq_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       empty;
      logic       full;
      logic       any_hit;
   } spq_stat_type;

endpackage

### design/spq_datapath.sv
// Datapath: chain of task cells with per-cell compare, hit marks and response registers.
// Depends on spq_pkg.
module spq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_func,
   input  logic [15:0]          req_task_id,
   input  logic [7:0]           req_task_priority,
   input  spq_pkg::spq_cmd_type cmd,
   output spq_pkg::spq_stat_type stat,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_removed_id,
   output logic [7:0]           rsp_removed_priority,
   output logic [4:0]           rsp_entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [15:0]   id_ff  [CAPACITY];
   logic [7:0]    pri_ff [CAPACITY];
   logic [15:0]   id_in  [CAPACITY];
   logic [7:0]    pri_in [CAPACITY];
   logic [CAPACITY-1:0] hit_ff, hit_in, gt, first, valid;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    func_ff;
   logic [15:0]   key_id_ff;
   logic [7:0]    key_pri_ff;
   logic [1:0]    status_ff;
   logic [15:0]   rid_ff, rid_in, sel_id;
   logic [7:0]    rpri_ff, rpri_in, sel_pri;
   logic [CW-1:0] rcount_ff;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i] = CW'(i) < count_ff;
         gt[i]    = valid[i] && (pri_ff[i] > key_pri_ff);
         first[i] = hit_ff[i] && ((i == 0) ? 1'b1 : !hit_ff[(i == 0) ? 0 : i - 1]);
      end
   end

   // One-hot select of the first matching cell
   always_comb begin
      sel_id  = '0;
      sel_pri = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_id  = sel_id  | ({16{first[i]}} & id_ff[i]);
         sel_pri = sel_pri | ({8{first[i]}} & pri_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         id_in[i]  = id_ff[i];
         pri_in[i] = pri_ff[i];
         hit_in[i] = hit_ff[i];
         if (cmd.do_insert && (gt[i] || CW'(i) == count_ff)) begin
            if (i == 0 || !gt[(i == 0) ? 0 : i - 1]) begin
               id_in[i]  = key_id_ff;
               pri_in[i] = key_pri_ff;
            end else begin
               id_in[i]  = id_ff[(i == 0) ? 0 : i - 1];
               pri_in[i] = pri_ff[(i == 0) ? 0 : i - 1];
            end
         end
         if ((cmd.do_pop || (cmd.do_remove && hit_ff[i])) && i + 1 < CAPACITY) begin
            id_in[i]  = id_ff[(i + 1 < CAPACITY) ? i + 1 : i];
            pri_in[i] = pri_ff[(i + 1 < CAPACITY) ? i + 1 : i];
         end
         if (cmd.load_hit)
            hit_in[i] = valid[i] && (id_ff[i] == key_id_ff);
         else if (cmd.spread && i > 0)
            hit_in[i] = hit_ff[i] || hit_ff[(i == 0) ? 0 : i - 1];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert)
         count_in = count_ff + CW'(1);
      else if (cmd.do_pop || cmd.do_remove)
         count_in = count_ff - CW'(1);
      rid_in  = '0;
      rpri_in = '0;
      if (cmd.do_pop) begin
         rid_in  = id_ff[0];
         rpri_in = pri_ff[0];
      end else if (cmd.do_remove) begin
         rid_in  = sel_id;
         rpri_in = sel_pri;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         id_ff[i]  <= id_in[i];
         pri_ff[i] <= pri_in[i];
      end
      hit_ff <= hit_in;
      if (cmd.latch) begin
         func_ff    <= req_func;
         key_id_ff  <= req_task_id;
         key_pri_ff <= req_task_priority;
      end
      if (cmd.finish) begin
         status_ff <= cmd.status;
         rid_ff    <= rid_in;
         rpri_ff   <= rpri_in;
         rcount_ff <= count_in;
      end
   end

   assign stat.func    = func_ff;
   assign stat.empty   = count_ff == '0;
   assign stat.full    = count_ff == CW'(CAPACITY);
   assign stat.any_hit = hit_ff[CAPACITY-1];

   assign rsp_status           = status_ff;
   assign rsp_removed_id       = rid_ff;
   assign rsp_removed_priority = rpri_ff;
   assign rsp_entry_count      = 5'(rcount_ff);

endmodule

### design/spq_ctrl.sv
// Controller: sequences one request at a time through the cell chain.
// Depends on spq_pkg.
module spq_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  spq_pkg::spq_stat_type stat,
   output spq_pkg::spq_cmd_type  cmd
);
   import spq_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SPREAD = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;
   localparam int SW = $clog2(CAPACITY);

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.status = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = 1'b1;
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in   = S_RESP;
            cmd.finish = 1'b1;
            case (stat.func)
               FUNC_INSERT: begin
                  if (stat.full) cmd.status = ST_FULL;
                  else cmd.do_insert = 1'b1;
               end
               FUNC_POP: begin
                  if (stat.empty) cmd.status = ST_EMPTY;
                  else cmd.do_pop = 1'b1;
               end
               FUNC_REMOVE: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.finish   = 1'b0;
                     cmd.load_hit = 1'b1;
                     step_in      = '0;
                     state_in     = S_SPREAD;
                  end
               end
               default: ;
            endcase
         end
         S_SPREAD: begin
            // spread the first hit towards the tail, one cell per cycle
            if (step_ff != SW'(CAPACITY - 1)) begin
               cmd.spread = 1'b1;
               step_in    = step_ff + SW'(1);
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_RESP;
               if (stat.any_hit) cmd.do_remove = 1'b1;
               else cmd.status = ST_NOT_FOUND;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule

### design/sorted_priority_queue_with_delete_top.sv
// Top level of the sorted priority queue with remove by id.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   Request channel (req_valid/req_ready): req_func selects insert, pop head
//   or remove by id; req_task_id and req_task_priority carry the task.
//   Response channel (rsp_valid/rsp_ready): one response per request with
//   status, removed task (zero when none) and the entry count afterwards.
//   Tasks sit in a chain of cells sorted by priority, smaller first, with
//   ties kept in arrival order. Insert and pop compare and shift every cell
//   at once.
//   Sequencing: insert, pop, remove on an empty queue and unused codes pass
//   from the execute state to the response state; remove by id on a non-empty
//   queue goes through the spread state in between, where the hit mark spreads
//   one cell per cycle through the chain. One request is in flight at a time,
//   so the next is accepted the cycle after the response is taken.
//   Reset empties the queue; cell contents are not cleared.
//   When rsp_ready is low the response holds and no request is accepted.
module sorted_priority_queue_with_delete_top #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_task_id,
   input  logic [7:0]  req_task_priority,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_removed_id,
   output logic [7:0]  rsp_removed_priority,
   output logic [4:0]  rsp_entry_count
);
   import spq_pkg::*;

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_func             (req_func),
      .req_task_id          (req_task_id),
      .req_task_priority    (req_task_priority),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_status           (rsp_status),
      .rsp_removed_id       (rsp_removed_id),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_entry_count      (rsp_entry_count)
   );

endmodule

### dv/sorted_priority_queue_with_delete_top_tb.sv
// Testbench for the sorted priority queue with remove by id: drives random and
// directed requests, predicts each response from a local queue copy and checks it.
// Depends on spq_pkg and sorted_priority_queue_with_delete_top.
`timescale 1ns / 1ps

module sorted_priority_queue_with_delete_top_tb;
   import spq_pkg::*;

   localparam int CAP = 16;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] rid;
      logic [7:0]  rpri;
      logic [4:0]  count;
   } queue_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [15:0] req_task_id = '0;
   logic [7:0]  req_task_priority = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_removed_id;
   logic [7:0]  rsp_removed_priority;
   logic [4:0]  rsp_entry_count;

   logic [15:0]      model_ids[CAP];
   logic [7:0]       model_pris[CAP];
   int               model_count = 0;
   queue_answer_type pending_answers[$];
   int               mismatches = 0;
   bit               quiet = 1'b0;    // no idling in either direction

   sorted_priority_queue_with_delete_top #(.CAPACITY(CAP)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("sorted_priority_queue_with_delete_top test failed");
      $finish;
   end

   function automatic queue_answer_type predict_queue(logic [1:0] f, logic [15:0] id,
                                                      logic [7:0] pri);
      queue_answer_type a;
      int pos;
      a = '0;
      a.status = ST_DONE;
      pos = -1;
      if (f == FUNC_INSERT) begin
         if (model_count >= CAP) begin
            a.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < model_count && model_pris[pos] <= pri) pos++;
            for (int k = model_count; k > pos; k--) begin
               model_ids[k] = model_ids[k-1];
               model_pris[k] = model_pris[k-1];
            end
            model_ids[pos] = id;
            model_pris[pos] = pri;
            model_count++;
            pos = -1;
         end
      end else if (f == FUNC_POP) begin
         if (model_count == 0) a.status = ST_EMPTY;
         else pos = 0;
      end else if (f == FUNC_REMOVE) begin
         if (model_count == 0) begin
            a.status = ST_EMPTY;
         end else begin
            pos = 0;
            while (pos < model_count && model_ids[pos] != id) pos++;
            if (pos >= model_count) begin
               a.status = ST_NOT_FOUND;
               pos = -1;
            end
         end
      end
      if (pos >= 0) begin
         a.rid = model_ids[pos];
         a.rpri = model_pris[pos];
         for (int k = pos; k + 1 < model_count; k++) begin
            model_ids[k] = model_ids[k+1];
            model_pris[k] = model_pris[k+1];
         end
         model_count--;
      end
      a.count = model_count[4:0];
      return a;
   endfunction

   // Response side: random stalls, compare with the oldest expectation.
   always @(posedge clock) begin
      queue_answer_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_removed_id, rsp_removed_priority, rsp_entry_count};
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 19);
      end
   end

   // Valid drops only while idling or draining, so each edge sees one assignment.
   task automatic send_request(logic [1:0] f, logic [15:0] id, logic [7:0] pri);
      while (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_task_id <= id;
      req_task_priority <= pri;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(predict_queue(f, id, pri));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (CAP + 4) @(posedge clock);
   endtask

   // Pick a live id now and then so removes hit.
   function automatic logic [15:0] pick_id();
      if (model_count != 0 && $urandom_range(2) != 0)
         return model_ids[$urandom_range(model_count - 1)];
      return 16'($urandom_range(15));
   endfunction

   task automatic test_empty_queue();
      send_request(FUNC_POP, 16'h0, 8'h0);
      send_request(FUNC_REMOVE, 16'hFFFF, 8'h0);
      send_request(FUNC_UNUSED, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_fill_and_overflow();
      // Extremes and ties; the last insert overflows.
      for (int i = 0; i <= CAP; i++)
         send_request(FUNC_INSERT, (i == 0) ? 16'hFFFF : 16'(i),
                      (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h80));
      send_request(FUNC_REMOVE, 16'hABCD, 8'h0);
      send_request(FUNC_REMOVE, 16'hFFFF, 8'h0);
      send_request(FUNC_UNUSED, 16'h5555, 8'h55);
      send_request(FUNC_POP, 16'h0, 8'h0);
      drain_responses();
   endtask

   task automatic test_random_mix(int n, bit no_idle);
      logic [1:0] f;
      quiet = no_idle;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(19))
            0,1,2,3,4,5,6,7: f = FUNC_INSERT;
            8,9,10,11,12:    f = FUNC_POP;
            19:              f = FUNC_UNUSED;
            default:         f = FUNC_REMOVE;
         endcase
         if ($urandom_range(3) == 0)
            send_request(f, 16'($urandom), 8'($urandom));
         else
            send_request(f, pick_id(), 8'($urandom_range(7)));
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_and_overflow();
      test_random_mix(800, 1'b0);
      drain_responses();
      test_random_mix(300, 1'b1);
      test_random_mix(800, 1'b0);
      drain_responses();
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("sorted_priority_queue_with_delete_top test passed");
      else
         $display("sorted_priority_queue_with_delete_top test failed");
      $finish;
   end
endmodule
